@@ hdl/numerov_recurrence_step_macros.svh @@
// Assertion macros for the Numerov recurrence step.
// Used by the top level only; needs no other file.
`ifndef NUMEROV_RECURRENCE_STEP_MACROS_SVH
`define NUMEROV_RECURRENCE_STEP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication under reset.
`define NRS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication under reset.
`define NRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define NRS_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define NRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ hdl/nrs_pkg.sv @@
// Shared types, widths and helpers for the Numerov recurrence step.
// No dependencies.
package nrs_pkg;

    localparam int Q_W       = 40;  // step coefficient width
    localparam int V_W       = 36;  // multiplicand width of a weight lane
    localparam int P_W       = 38;  // rounded lane product width
    localparam int C_W       = 31;  // clipped weight width
    localparam int NUM_W     = 64;  // numerator width
    localparam int MAG_W     = 63;  // numerator magnitude width
    localparam int DIV_STEPS = 63;
    localparam int CNT_W     = 6;

    localparam logic [1:0] CFG_LAMBDA = 2'd0;
    localparam logic [1:0] CFG_QCOEF  = 2'd1;
    localparam logic [1:0] CFG_START  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COEF,
        ST_CLIP,
        ST_MIX,
        ST_NUM,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic q_bit;
    } t_mul_ctl;

    typedef struct packed {
        logic             done;
        logic             neg;
        logic [MAG_W-1:0] quot;
    } t_div_out;

    typedef struct packed {
        logic                  flag;
        logic signed [C_W-1:0] val;
    } t_clip;

    // Clip a 40-bit signed value to the signed 31-bit range.
    function automatic t_clip clip31(input logic signed [39:0] v);
        t_clip r;
        if (v > 40'sd1073741823) begin
            r.flag = 1'b1;
            r.val  = 31'sh3FFFFFFF;
        end else if (v < -40'sd1073741824) begin
            r.flag = 1'b1;
            r.val  = 31'sh40000000;
        end else begin
            r.flag = 1'b0;
            r.val  = v[C_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ hdl/nrs_coef_mul.sv @@
// One weight lane: serial product of the step coefficient and a value,
// one coefficient bit per cycle while step is set, LSB first, rounded half up. Uses nrs_pkg.
module nrs_coef_mul
    import nrs_pkg::*;
(
    input  logic                  i_clk,
    input  t_mul_ctl              i_ctl,
    input  logic signed [V_W-1:0] i_v,
    output logic signed [P_W-1:0] o_prod
);

    logic signed [V_W-1:0] r_v;
    logic signed [P_W-1:0] r_hi;
    logic                  r_rb;
    logic signed [P_W-1:0] w_sum;

    // Low product bits leave at the bottom; only the last one (bit 39)
    // is kept for rounding.
    assign w_sum  = r_hi + (i_ctl.q_bit ? P_W'(r_v) : '0);
    assign o_prod = r_hi + P_W'({1'b0, r_rb});

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_v  <= i_v;
            r_hi <= '0;
            r_rb <= 1'b0;
        end else if (i_ctl.step) begin
            r_hi <= w_sum >>> 1;
            r_rb <= w_sum[0];
        end
    end

endmodule

@@ hdl/nrs_serial_div.sv @@
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Returns magnitude and sign of the quotient. Uses nrs_pkg.
module nrs_serial_div
    import nrs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic signed [C_W-1:0]   i_den,
    output t_div_out                o_res
);

    logic             r_busy;
    logic             r_done;
    logic             r_neg;
    logic [MAG_W-1:0] r_n;
    logic [MAG_W-1:0] r_q;
    logic [C_W-1:0]   r_dm;
    logic [C_W-1:0]   r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic [C_W:0]     w_trial;
    logic             w_ge;
    logic [NUM_W-1:0] w_nabs;
    logic [C_W-1:0]   w_dabs;

    assign w_nabs  = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
    assign w_dabs  = i_den[C_W-1] ? C_W'(-i_den) : C_W'(i_den);
    assign w_trial = {r_rem, r_n[MAG_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dm};

    assign o_res.done = r_done;
    assign o_res.neg  = r_neg;
    assign o_res.quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[NUM_W-1] ^ i_den[C_W-1];
            r_n   <= w_nabs[MAG_W-1:0];
            r_dm  <= w_dabs;
            r_rem <= '0;
            r_q   <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? C_W'(w_trial - {1'b0, r_dm}) : w_trial[C_W-1:0];
            r_q   <= {r_q[MAG_W-2:0], w_ge};
            r_n   <= r_n << 1;
            r_cnt <= r_cnt + 1'b1;
        end
    end

endmodule

@@ hdl/numerov_recurrence_step.sv @@
// Numerov recurrence step: one new solution value per item, signed fixed point.
// An accepted item passes ST_COEF (coefficient-serial weights), ST_CLIP, ST_MIX
// (weight-serial numerator), ST_NUM, ST_DIV (divider) and ST_DONE. A zero leading
// weight skips the numerator and the divider. One item at a time: a new item is taken
// only after the last result is loaded to the output register, held off while stalled.
// Synchronous active-low reset restores register defaults and history; uses nrs_pkg.
`include "numerov_recurrence_step_macros.svh"
module numerov_recurrence_step
    import nrs_pkg::*;
#(
    parameter int FRAC_BITS = 16
)(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [39:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_pot_behind,
    input  logic signed [31:0] i_pot_here,
    input  logic signed [31:0] i_pot_ahead,
    input  logic signed [31:0] i_src_behind,
    input  logic signed [31:0] i_src_here,
    input  logic signed [31:0] i_src_ahead,
    input  logic               i_restart,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_y_next,
    output logic               o_saturated,
    output logic               o_div_fault
);

    localparam logic signed [39:0] ONE_W = 40'sd1 <<< FRAC_BITS;

    // Configuration registers.
    logic signed [31:0] r_lam;
    logic [Q_W-1:0]     r_qcfg;
    logic signed [31:0] r_start;

    // History and control.
    t_state             r_state, n_state;
    logic signed [31:0] r_y_old, r_y_new;
    logic [Q_W-1:0]     r_qsh;
    logic [CNT_W-1:0]   r_cnt;

    // Weights and flags of the item at work.
    logic signed [C_W-1:0] r_c1, r_c4;
    logic [C_W-1:0]        r_c2sh, r_c3sh;
    logic                  r_sat, r_fault;
    logic signed [34:0]    r_mhi;
    logic [C_W-1:0]        r_mlo;
    logic signed [31:0]    r_y_res;

    // Output register.
    logic               r_o_valid, r_o_sat, r_o_fault;
    logic signed [31:0] r_o_y;

    // Control from the sequencer.
    logic     w_accept, w_div_start, w_out_load;
    t_mul_ctl w_mctl;
    t_div_out w_div;

    // Lane operands, formed when an item is accepted.
    logic signed [32:0]    w_k_b, w_k_h, w_k_a;
    logic signed [V_W-1:0] w_v_b, w_v_h, w_v_a, w_v_s;
    logic signed [P_W-1:0] w_p_b, w_p_h, w_p_a, w_p_s;
    t_clip                 w_c1, w_c2, w_c3, w_c4;

    // Numerator and result saturation.
    logic signed [33:0]    w_term, w_term_s;
    logic signed [34:0]    w_msum;
    logic signed [NUM_W-1:0] w_num;
    logic signed [31:0]    w_y_sat;
    logic                  w_q_clip;

    assign w_accept = i_valid && !o_stall;
    assign o_stall  = (r_state != ST_IDLE);

    assign o_valid     = r_o_valid;
    assign o_y_next    = r_o_y;
    assign o_saturated = r_o_sat;
    assign o_div_fault = r_o_fault;

    // k = lambda - g at each point; the middle one enters as 5k, and the
    // source lane takes s(x-h) + 10 s(x) + s(x+h).
    assign w_k_b = 33'(r_lam) - 33'(i_pot_behind);
    assign w_k_h = 33'(r_lam) - 33'(i_pot_here);
    assign w_k_a = 33'(r_lam) - 33'(i_pot_ahead);
    assign w_v_b = V_W'(w_k_b);
    assign w_v_a = V_W'(w_k_a);
    assign w_v_h = (V_W'(w_k_h) <<< 2) + V_W'(w_k_h);
    assign w_v_s = V_W'(i_src_behind) + (V_W'(i_src_here) <<< 3)
                 + (V_W'(i_src_here) <<< 1) + V_W'(i_src_ahead);

    // All four lanes share the coefficient bit stream.
    nrs_coef_mul u_mul_a (.i_clk(i_clk), .i_ctl(w_mctl), .i_v(w_v_a), .o_prod(w_p_a));
    nrs_coef_mul u_mul_h (.i_clk(i_clk), .i_ctl(w_mctl), .i_v(w_v_h), .o_prod(w_p_h));
    nrs_coef_mul u_mul_b (.i_clk(i_clk), .i_ctl(w_mctl), .i_v(w_v_b), .o_prod(w_p_b));
    nrs_coef_mul u_mul_s (.i_clk(i_clk), .i_ctl(w_mctl), .i_v(w_v_s), .o_prod(w_p_s));

    assign w_c1 = clip31(ONE_W + 40'(w_p_a));
    assign w_c2 = clip31((ONE_W - 40'(w_p_h)) <<< 1);
    assign w_c3 = clip31(ONE_W + 40'(w_p_b));
    assign w_c4 = clip31(40'(w_p_s));

    // The numerator difference y_newer*c2 - y_older*c3 is built one weight
    // bit per cycle, LSB first; the weights' sign bit carries negative weight.
    assign w_term   = (r_c2sh[0] ? 34'(r_y_new) : 34'sd0)
                    - (r_c3sh[0] ? 34'(r_y_old) : 34'sd0);
    assign w_term_s = (r_cnt == CNT_W'(C_W - 1)) ? -w_term : w_term;
    assign w_msum   = r_mhi + 35'(w_term_s);
    assign w_num    = NUM_W'({r_mhi, r_mlo}) + (NUM_W'(r_c4) <<< FRAC_BITS);

    nrs_serial_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (r_c1),
        .o_res   (w_div)
    );

    // Clip the quotient magnitude to the signed 32-bit range.
    always_comb begin
        w_q_clip = 1'b0;
        if (!w_div.neg && w_div.quot > MAG_W'(32'h7FFFFFFF)) begin
            w_q_clip = 1'b1;
            w_y_sat  = 32'sh7FFFFFFF;
        end else if (w_div.neg && w_div.quot > MAG_W'(33'h080000000)) begin
            w_q_clip = 1'b1;
            w_y_sat  = 32'sh80000000;
        end else if (w_div.neg) begin
            w_y_sat = -$signed(w_div.quot[31:0]);
        end else begin
            w_y_sat = $signed(w_div.quot[31:0]);
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        w_mctl.load  = 1'b0;
        w_mctl.step  = 1'b0;
        w_mctl.q_bit = r_qsh[0];
        w_div_start  = 1'b0;
        w_out_load   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    w_mctl.load = 1'b1;
                    n_state     = ST_COEF;
                end
            end
            ST_COEF: begin
                w_mctl.step = 1'b1;
                if (r_cnt == CNT_W'(Q_W - 1)) begin
                    n_state = ST_CLIP;
                end
            end
            ST_CLIP: begin
                n_state = (w_c1.val == '0) ? ST_DONE : ST_MIX;
            end
            ST_MIX: begin
                if (r_cnt == CNT_W'(C_W - 1)) begin
                    n_state = ST_NUM;
                end
            end
            ST_NUM: begin
                w_div_start = 1'b1;
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                if (w_div.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_o_valid || !i_stall) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Configuration and history; restart acts when the item is accepted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lam   <= '0;
            r_qcfg  <= Q_W'(40'd91625969);
            r_start <= 32'sd65536;
            r_y_old <= 32'sd65536;
            r_y_new <= 32'sd65536;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LAMBDA: r_lam   <= i_cfg_data[31:0];
                    CFG_QCOEF:  r_qcfg  <= i_cfg_data;
                    CFG_START:  r_start <= i_cfg_data[31:0];
                    default: begin
                    end
                endcase
            end
            if (w_accept && i_restart) begin
                r_y_old <= r_start;
                r_y_new <= r_start;
            end else if (r_state == ST_DIV && w_div.done) begin
                r_y_old <= r_y_new;
                r_y_new <= w_y_sat;
            end
        end
    end

    // Datapath of the item at work.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_qsh   <= r_qcfg;
                r_cnt   <= '0;
                r_sat   <= 1'b0;
                r_fault <= 1'b0;
            end
            ST_COEF: begin
                r_qsh <= r_qsh >> 1;
                r_cnt <= r_cnt + 1'b1;
            end
            ST_CLIP: begin
                r_c1    <= w_c1.val;
                r_c4    <= w_c4.val;
                r_c2sh  <= w_c2.val;
                r_c3sh  <= w_c3.val;
                r_mhi   <= '0;
                r_mlo   <= '0;
                r_cnt   <= '0;
                r_sat   <= w_c1.flag | w_c2.flag | w_c3.flag | w_c4.flag;
                r_fault <= (w_c1.val == '0);
                r_y_res <= '0;
            end
            ST_MIX: begin
                r_mhi  <= w_msum >>> 1;
                r_mlo  <= {w_msum[0], r_mlo[C_W-1:1]};
                r_c2sh <= r_c2sh >> 1;
                r_c3sh <= r_c3sh >> 1;
                r_cnt  <= r_cnt + 1'b1;
            end
            ST_DIV: begin
                if (w_div.done) begin
                    r_y_res <= w_y_sat;
                    r_sat   <= r_sat | w_q_clip;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register; a fault reports zero and no saturation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_y     <= r_y_res;
            r_o_sat   <= r_sat & ~r_fault;
            r_o_fault <= r_fault;
        end
    end

    `NRS_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, w_accept, r_state == ST_COEF)
    `NRS_ASSERT_NOW(a_done_in_div, i_clk, i_rst_n, w_div.done, r_state == ST_DIV)
    `NRS_ASSERT_NOW(a_fault_zero, i_clk, i_rst_n, o_valid && o_div_fault,
                    o_y_next == 32'sd0 && !o_saturated)
    `NRS_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, w_out_load, o_valid)

endmodule

@@ test/nrs_step_checker.sv @@
// Checker for the Numerov recurrence step: follows the config port and both channels,
// predicts each result, and compares it with what the block returns. Uses nrs_pkg.
`timescale 1ns / 100ps
module nrs_step_checker
    import nrs_pkg::*;
#(
    parameter int FRAC_BITS = 16
)(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [39:0]        i_cfg_data,
    input  logic               i_valid,
    input  logic               i_in_stall,
    input  logic signed [31:0] i_pot_behind,
    input  logic signed [31:0] i_pot_here,
    input  logic signed [31:0] i_pot_ahead,
    input  logic signed [31:0] i_src_behind,
    input  logic signed [31:0] i_src_here,
    input  logic signed [31:0] i_src_ahead,
    input  logic               i_restart,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_y_next,
    input  logic               i_saturated,
    input  logic               i_div_fault,
    output int                 o_pending,
    output int                 o_errors,
    output int                 o_faults,
    output int                 o_clipped
);

    typedef struct {
        logic signed [31:0] y;
        logic               sat;
        logic               fault;
    } t_y_result;

    localparam longint WGT_MAX = 64'sd1073741823;
    localparam longint WGT_MIN = -64'sd1073741824;

    logic signed [31:0] lambda_r;
    logic [39:0]        qcoef_r;
    logic signed [31:0] start_r;
    longint             hist_old;
    longint             hist_new;
    t_y_result          y_queue[$];

    // Round q * v / 2^40 to nearest, ties toward plus infinity.
    function automatic longint scale_by_q(logic [39:0] q, longint v);
        logic signed [127:0] p;
        p = v;
        p = p * $signed({88'd0, q});
        p = p + (128'sd1 <<< 39);
        return longint'(p >>> 40);
    endfunction

    function automatic longint clip_to(longint v, longint lo, longint hi, ref logic flag);
        if (v > hi) begin
            flag = 1'b1;
            return hi;
        end
        if (v < lo) begin
            flag = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // Advance the predicted history by one item and return the expected result.
    function automatic t_y_result predict_y(longint pb, longint ph, longint pa,
                                            longint sb, longint sh, longint sa,
                                            logic rst_hist);
        t_y_result r;
        longint one, c1, c2, c3, c4, quo;
        logic signed [127:0] num;
        logic sat;
        one = longint'(1) << FRAC_BITS;
        sat = 1'b0;
        if (rst_hist) begin
            hist_old = longint'(start_r);
            hist_new = longint'(start_r);
        end
        c1 = clip_to(one + scale_by_q(qcoef_r, longint'(lambda_r) - pa), WGT_MIN, WGT_MAX, sat);
        c2 = clip_to(2 * (one - scale_by_q(qcoef_r, 5 * (longint'(lambda_r) - ph))),
                     WGT_MIN, WGT_MAX, sat);
        c3 = clip_to(one + scale_by_q(qcoef_r, longint'(lambda_r) - pb), WGT_MIN, WGT_MAX, sat);
        c4 = clip_to(scale_by_q(qcoef_r, sb + 10 * sh + sa), WGT_MIN, WGT_MAX, sat);
        if (c1 == 0) begin
            // Zero leading weight: fault, history untouched.
            r.y = '0;
            r.sat = 1'b0;
            r.fault = 1'b1;
            return r;
        end
        num = 128'(hist_new) * 128'(c2) - 128'(hist_old) * 128'(c3) + 128'(c4) * 128'(one);
        quo = clip_to(longint'(num / 128'(c1)), -64'sd2147483648, 64'sd2147483647, sat);
        hist_old = hist_new;
        hist_new = quo;
        r.y = quo[31:0];
        r.sat = sat;
        r.fault = 1'b0;
        return r;
    endfunction

    assign o_pending = y_queue.size();

    always @(posedge i_clk) begin
        t_y_result exp_r;
        if (!i_rst_n) begin
            lambda_r <= '0;
            qcoef_r  <= 40'd91625969;
            start_r  <= 32'sd65536;
            hist_old = 65536;
            hist_new = 65536;
            y_queue.delete();
        end else begin
            if (i_valid && !i_in_stall) begin
                y_queue.push_back(predict_y(i_pot_behind, i_pot_here, i_pot_ahead,
                                            i_src_behind, i_src_here, i_src_ahead,
                                            i_restart));
            end
            if (i_out_valid && !i_out_stall) begin
                if (y_queue.size() == 0) begin
                    $error("unexpected result y_next=%0d", i_y_next);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = y_queue.pop_front();
                    if (i_div_fault) o_faults <= o_faults + 1;
                    if (i_saturated) o_clipped <= o_clipped + 1;
                    if (i_y_next !== exp_r.y || i_saturated !== exp_r.sat ||
                        i_div_fault !== exp_r.fault) begin
                        if (i_y_next !== exp_r.y)
                            $error("y_next: expected %0d, got %0d", exp_r.y, i_y_next);
                        if (i_saturated !== exp_r.sat)
                            $error("saturated: expected %0b, got %0b", exp_r.sat, i_saturated);
                        if (i_div_fault !== exp_r.fault)
                            $error("div_fault: expected %0b, got %0b", exp_r.fault, i_div_fault);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LAMBDA: lambda_r <= i_cfg_data[31:0];
                    CFG_QCOEF:  qcoef_r  <= i_cfg_data;
                    CFG_START:  start_r  <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
        end
    end

    initial begin
        o_errors  = 0;
        o_faults  = 0;
        o_clipped = 0;
    end

endmodule

@@ test/tb_top.sv @@
// Testbench top for the Numerov recurrence step: clock, reset, stimulus and verdict.
// Depends on nrs_pkg, the block and nrs_step_checker.
`timescale 1ns / 100ps
module tb_top;
    import nrs_pkg::*;

    // Index that selects no register; writes to it must change nothing.
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int         NUM_PHASES = 6;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = CFG_LAMBDA;
    logic [39:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [31:0] i_pot_behind = '0;
    logic signed [31:0] i_pot_here = '0;
    logic signed [31:0] i_pot_ahead = '0;
    logic signed [31:0] i_src_behind = '0;
    logic signed [31:0] i_src_here = '0;
    logic signed [31:0] i_src_ahead = '0;
    logic               i_restart = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_y_next;
    logic               o_saturated;
    logic               o_div_fault;

    int pending, errors, faults, clipped;
    int items_sent = 0;
    bit hold_req = 1'b0;   // asks the receiver for one long hold-off
    bit calm = 1'b0;       // when set, neither side idles

    always #5 i_clk = ~i_clk;

    numerov_recurrence_step u_top (.*);

    nrs_step_checker u_chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .i_in_stall(o_stall),
        .i_pot_behind, .i_pot_here, .i_pot_ahead,
        .i_src_behind, .i_src_here, .i_src_ahead, .i_restart,
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_y_next(o_y_next), .i_saturated(o_saturated), .i_div_fault(o_div_fault),
        .o_pending(pending), .o_errors(errors), .o_faults(faults), .o_clipped(clipped)
    );

    // Write one register through the configuration port.
    task automatic write_reg(logic [1:0] idx, logic [39:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Offer one item after a random gap (none if calm); wait until the block takes it.
    // Stall comes from registered state only, so sampling it at the falling edge is safe.
    task automatic send_item(logic signed [31:0] pb, ph, pa, sb, sh, sa, logic rs);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_pot_behind <= pb;
        i_pot_here   <= ph;
        i_pot_ahead  <= pa;
        i_src_behind <= sb;
        i_src_here   <= sh;
        i_src_ahead  <= sa;
        i_restart    <= rs;
        forever begin
            @(negedge i_clk);
            if (!o_stall) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
        items_sent++;
    endtask

    // Random value: mostly near the operating range, sometimes any 32-bit word.
    function automatic logic signed [31:0] pick_val();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
            2: return $signed($urandom_range(0, 32'h0000_2000)) - 32'sh0000_1000;
            default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
        endcase
    endfunction

    // Wait until the checker holds no expectation, then let the block settle.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    // Receiver: a random hold-off before each result, one long hold-off on request.
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (600) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                n = calm ? 0 : $urandom_range(0, 7);
                if (n > 0) begin
                    i_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
            end
            i_stall <= 1'b0;
            forever begin
                @(negedge i_clk);
                if (o_valid) break;
                @(posedge i_clk);
            end
            @(posedge i_clk);
        end
    end

    initial begin
        logic signed [31:0] lam_set[NUM_PHASES];
        logic [39:0]        q_set[NUM_PHASES];
        logic signed [31:0] start_set[NUM_PHASES];
        logic signed [31:0] pa;
        logic [39:0]        half_q;
        half_q = 40'h80_0000_0000;
        // Settings per phase, extremes among them. Phase 3 and 4 use q values at
        // which a chosen potential makes the leading weight exactly zero.
        lam_set   = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0001_0000, 32'sh0000_0000,
                      -32'sh0003_0000, 32'sh0000_4000};
        q_set     = '{40'd0, 40'hFF_FFFF_FFFF, 40'd91625969, half_q, 40'hFF_FFFF_FFFF,
                      40'd1 << 30};
        start_set = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, 32'sh0001_0000,
                      -32'sh0000_8000, 32'sh0000_0123};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, at reset settings then q near 1: field extremes, restarts, zero divisor.
        send_item(0, 0, 0, 0, 0, 0, 1'b0);
        send_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
        send_item(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
        send_item(-1, -1, -1, -1, -1, -1, 1'b0);
        send_item(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                  32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
        send_item(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 1, 2, 3, 1'b1);
        drain();
        write_reg(CFG_QCOEF, 40'hFF_FFFF_FFFF);
        write_reg(CFG_UNUSED, 40'hFF_FFFF_FFFF);
        // With q near one and lambda zero, a potential of 1.0 ahead zeroes the divisor.
        send_item(0, 0, 32'sh0001_0000, 0, 0, 0, 1'b0);
        send_item(0, 0, 32'sh0001_0000, 0, 0, 0, 1'b1);
        send_item(0, 32'sh7FFF_FFFF, 0, 0, 32'sh7FFF_FFFF, 0, 1'b0);
        send_item(0, 0, 32'sh8000_0000, 0, 0, 32'sh8000_0000, 1'b0);
        send_item(32'sh8000_0000, 0, 0, 0, 32'sh8000_0000, 0, 1'b0);
        send_item(0, 0, -32'sh0000_8000, 0, 0, 0, 1'b0);
        send_item(0, 0, 32'sh0000_8000, 0, 0, 0, 1'b0);
        send_item(0, 0, 32'sh0000_FFFF, 0, 0, 0, 1'b0);
        drain();

        // Random phases; the sender pauses until all results are in before each
        // set of register writes.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_reg(CFG_LAMBDA, {8'd0, lam_set[ph]});
            write_reg(CFG_QCOEF, q_set[ph]);
            write_reg(CFG_START, {8'd0, start_set[ph]});
            if (ph == 1) hold_req = 1'b1;
            for (int i = 0; i < 190; i++) begin
                if (i % 60 == 0) calm = ($urandom_range(0, 2) == 0);
                pa = pick_val();
                // Aim at a zero divisor now and then where the setting allows it.
                if ((ph == 3 || ph == 4) && $urandom_range(0, 7) == 0)
                    pa = lam_set[ph] + ((ph == 3) ? 32'sh0002_0000 : 32'sh0001_0000);
                send_item(pick_val(), pick_val(), pa, pick_val(), pick_val(), pick_val(),
                          $urandom_range(0, 15) == 0);
            end
            calm = 1'b0;
            drain();
        end

        $display("Sent %0d items over %0d register settings.", items_sent, NUM_PHASES + 2);
        $display("Results: %0d divisor faults, %0d saturated.", faults, clipped);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/nrs_pkg.sv
hdl/nrs_coef_mul.sv
hdl/nrs_serial_div.sv
hdl/numerov_recurrence_step.sv
test/nrs_step_checker.sv
test/tb_top.sv
